@@ hdl/greedy_text_justifier_assert.svh @@
// Assertion helpers for the text justifier.
// Each macro takes a label, clock, active-low reset, trigger, check and message.
`ifndef GREEDY_TEXT_JUSTIFIER_ASSERT_SVH
`define GREEDY_TEXT_JUSTIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GTJ_ASSERT_IMP(lbl, clk, rstn, trig, chk, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (chk)) \
    else $error(msg);
// next-cycle implication
`define GTJ_ASSERT_NXT(lbl, clk, rstn, trig, chk, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (chk)) \
    else $error(msg);
`else
`define GTJ_ASSERT_IMP(lbl, clk, rstn, trig, chk, msg)
`define GTJ_ASSERT_NXT(lbl, clk, rstn, trig, chk, msg)
`endif
`endif

@@ hdl/gtj_pkg.sv @@
// Shared constants of the text justifier.
package gtj_pkg;

  // widest line the buffers are sized for
  localparam int unsigned MAX_WIDTH = 32;
  // character and line-width register widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CFG_W  = 6;
  // line width after reset
  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 6'd16;
  // padding character
  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

endpackage

@@ hdl/greedy_text_justifier.sv @@
// Greedy fully justified text formatter. Characters of a word arrive one per
// input word (tlast marks the word end, tuser the text end) and are kept in a
// word buffer; at the word end the block tests the fit in a check state,
// emits the pending line if the word does not fit, then copies the word into
// the line buffer at one character per cycle. A line comes out as exactly
// line_width characters (0 counts as 1, above MAX_WIDTH as MAX_WIDTH), one
// per cycle while the sink is ready, after a setup state, the gap divider
// for a fully justified line and a fetch of the first word length from the
// length memory, and it pauses at each later word of the line to fetch its
// length. Input is taken only while no line is being built or emitted, so a
// word is received, tested and copied without output, plus the emission of
// any line it completes. Writing line_width clears the pending line and the
// word being received.
`include "greedy_text_justifier_assert.svh"
module greedy_text_justifier #(
  parameter int unsigned MAX_WIDTH = gtj_pkg::MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // line width register
  input  logic                           cfg_we_i,
  input  logic [gtj_pkg::CFG_W-1:0]      cfg_wdata_i,
  // character stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [gtj_pkg::CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_code
  input  logic                           s_axis_tlast,   // word_end
  input  logic                           s_axis_tuser,   // [0] text_end
  // justified line stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [gtj_pkg::CHAR_W-1:0]     m_axis_tdata,   // [7:0] out_char
  output logic                           m_axis_tlast,   // line_end
  output logic                           m_axis_tuser    // [0] text_done
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SLOTS = MAX_WIDTH / 2 + 1;
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned WCW   = $clog2(SLOTS + 1);
  localparam int unsigned SUMW  = CW + 2;
  localparam int unsigned CHW   = gtj_pkg::CHAR_W;
  localparam int unsigned CFW   = gtj_pkg::CFG_W;
  localparam int unsigned CHKW  = 2 * CW + WCW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_APPEND,
    ST_PREP,
    ST_DIV,
    ST_LOAD,
    ST_OUT
  } state_e;

  state_e         state_q, state_d;
  logic [CFW-1:0] lw_q, lw_d;
  logic [CW-1:0]  wl_q, wl_d;      // chars kept of the current word
  logic [WCW-1:0] wc_q, wc_d;      // words in the pending line
  logic [CW-1:0]  lcc_q, lcc_d;    // chars in the pending line
  logic [AW-1:0]  cp_q, cp_d;      // copy index into the word
  logic           tend_q, tend_d;
  logic           full_q, full_d;
  logic           last_q, last_d;
  logic [SW-1:0]  k_q, k_d;        // word being emitted
  logic [CW-1:0]  rem_q, rem_d;    // chars left of that word
  logic [CW-1:0]  gl_q, gl_d;      // spaces left of the gap before it
  logic [CW-1:0]  gap_q, gap_d;
  logic [WCW-1:0] extra_q, extra_d;
  logic [AW-1:0]  src_q, src_d;
  logic [AW-1:0]  pos_q, pos_d;
  logic           mv_q, mv_d;
  logic [CHW-1:0] mc_q, mc_d;
  logic           meol_q, meol_d;
  logic           mdone_q, mdone_d;

  // memories and their ports
  logic [CHW-1:0] word_mem [MAX_WIDTH];
  logic [CHW-1:0] line_mem [MAX_WIDTH];
  logic [CW-1:0]  len_mem  [SLOTS];
  logic [CHW-1:0] word_rdata_q, line_rdata_q;
  logic [CW-1:0]  len_rdata_q;
  logic           word_we, line_we, len_we;
  logic [AW-1:0]  word_waddr, line_waddr;
  logic [SW-1:0]  len_waddr;

  logic [CW-1:0]  w;
  logic           s_acc, out_free, more_words, eol;
  logic [SUMW-1:0] fit_sum;
  logic           div_start, div_done;
  logic [CW-1:0]  div_total, div_quo;
  logic [WCW-1:0] div_gaps, div_rem;

  // effective line width
  always_comb begin
    if (lw_q == '0) begin
      w = CW'(1);
    end else if (lw_q > CFW'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = lw_q[CW-1:0];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !mv_q || m_axis_tready;
  assign fit_sum       = SUMW'(lcc_q) + SUMW'(wc_q) + SUMW'(wl_q);
  assign more_words    = (WCW'(k_q) + 1'b1) < wc_q;
  assign eol           = (CW'(pos_q) + 1'b1) == w;
  assign div_total     = w - lcc_q;
  assign div_gaps      = wc_q - 1'b1;
  assign word_waddr    = wl_q[AW-1:0];
  assign line_waddr    = AW'(lcc_q + CW'(cp_q));
  assign len_waddr     = wc_q[SW-1:0];

  // sequencer
  always_comb begin
    state_d   = state_q;
    lw_d      = lw_q;
    wl_d      = wl_q;
    wc_d      = wc_q;
    lcc_d     = lcc_q;
    cp_d      = cp_q;
    tend_d    = tend_q;
    full_d    = full_q;
    last_d    = last_q;
    k_d       = k_q;
    rem_d     = rem_q;
    gl_d      = gl_q;
    gap_d     = gap_q;
    extra_d   = extra_q;
    src_d     = src_q;
    pos_d     = pos_q;
    mv_d      = mv_q && !m_axis_tready;
    mc_d      = mc_q;
    meol_d    = meol_q;
    mdone_d   = mdone_q;
    word_we   = 1'b0;
    line_we   = 1'b0;
    len_we    = 1'b0;
    div_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          // keep the char unless the word is already a full line
          if (wl_q < w) begin
            word_we = 1'b1;
            wl_d    = wl_q + 1'b1;
          end
          if (s_axis_tlast) begin
            tend_d  = s_axis_tuser;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // word does not fit beside the pending line
        if (wc_q != '0 && fit_sum > SUMW'(w)) begin
          full_d  = wc_q > WCW'(1);
          last_d  = 1'b0;
          state_d = ST_PREP;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        line_we = 1'b1;
        if ((CW'(cp_q) + 1'b1) == wl_q) begin
          len_we = 1'b1;
          wc_d   = wc_q + 1'b1;
          lcc_d  = lcc_q + wl_q;
          wl_d   = '0;
          cp_d   = '0;
          if (tend_q) begin
            tend_d  = 1'b0;
            full_d  = 1'b0;
            last_d  = 1'b1;
            state_d = ST_PREP;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          cp_d = cp_q + 1'b1;
        end
      end
      ST_PREP: begin
        k_d   = '0;
        src_d = '0;
        pos_d = '0;
        if (full_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          gap_d   = CW'(1);
          extra_d = '0;
          state_d = ST_LOAD;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          gap_d   = div_quo;
          extra_d = div_rem;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // leftmost gaps take one extra space
        rem_d = len_rdata_q;
        if (k_q == '0) begin
          gl_d = '0;
        end else begin
          gl_d = gap_q + CW'(WCW'(k_q) <= extra_q);
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (gl_q == '0 && rem_q == '0 && more_words) begin
          k_d     = k_q + 1'b1;
          state_d = ST_LOAD;
        end else if (out_free) begin
          mv_d    = 1'b1;
          meol_d  = eol;
          mdone_d = eol && last_q;
          pos_d   = pos_q + 1'b1;
          if (gl_q != '0) begin
            mc_d = gtj_pkg::SPACE_CODE;
            gl_d = gl_q - 1'b1;
          end else if (rem_q != '0) begin
            mc_d  = line_rdata_q;
            rem_d = rem_q - 1'b1;
            src_d = src_q + 1'b1;
          end else begin
            mc_d = gtj_pkg::SPACE_CODE;
          end
          if (eol) begin
            wc_d    = '0;
            lcc_d   = '0;
            k_d     = '0;
            src_d   = '0;
            pos_d   = '0;
            last_d  = 1'b0;
            state_d = last_q ? ST_IDLE : ST_APPEND;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // width write drops the pending text
    if (cfg_we_i) begin
      lw_d    = cfg_wdata_i;
      wl_d    = '0;
      wc_d    = '0;
      lcc_d   = '0;
      cp_d    = '0;
      k_d     = '0;
      src_d   = '0;
      pos_d   = '0;
      tend_d  = 1'b0;
      full_d  = 1'b0;
      last_d  = 1'b0;
      word_we = 1'b0;
      line_we = 1'b0;
      len_we  = 1'b0;
      state_d = ST_IDLE;
    end
  end

  // control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lw_q    <= gtj_pkg::LINE_WIDTH_RST;
      wl_q    <= '0;
      wc_q    <= '0;
      lcc_q   <= '0;
      cp_q    <= '0;
      tend_q  <= 1'b0;
      full_q  <= 1'b0;
      last_q  <= 1'b0;
      k_q     <= '0;
      rem_q   <= '0;
      gl_q    <= '0;
      src_q   <= '0;
      pos_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      lw_q    <= lw_d;
      wl_q    <= wl_d;
      wc_q    <= wc_d;
      lcc_q   <= lcc_d;
      cp_q    <= cp_d;
      tend_q  <= tend_d;
      full_q  <= full_d;
      last_q  <= last_d;
      k_q     <= k_d;
      rem_q   <= rem_d;
      gl_q    <= gl_d;
      src_q   <= src_d;
      pos_q   <= pos_d;
      mv_q    <= mv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    gap_q   <= gap_d;
    extra_q <= extra_d;
    mc_q    <= mc_d;
    meol_q  <= meol_d;
    mdone_q <= mdone_d;
  end

  // word buffer, read ahead at the next copy index
  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[word_waddr] <= s_axis_tdata;
    end
    word_rdata_q <= word_mem[cp_d];
  end

  // line buffer, read ahead at the next source index
  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[line_waddr] <= word_rdata_q;
    end
    line_rdata_q <= line_mem[src_d];
  end

  // word length memory, read ahead at the next word index
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= wl_q;
    end
    len_rdata_q <= len_mem[k_d];
  end

  // gap size and leftover spaces
  gtj_div #(
    .ND(CW),
    .DV(WCW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_total),
    .divisor_i  (div_gaps),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mc_q;
  assign m_axis_tlast  = meol_q;
  assign m_axis_tuser  = mdone_q;

  // checks
  `GTJ_ASSERT_IMP(a_wc_bound, clk_i, rst_ni, 1'b1, wc_q < WCW'(SLOTS), "word slots overflow")
  `GTJ_ASSERT_IMP(a_line_fits, clk_i, rst_ni, wc_q != '0,
                  (SUMW'(lcc_q) + SUMW'(wc_q)) <= (SUMW'(w) + 1'b1),
                  "pending line wider than width")
  `GTJ_ASSERT_NXT(a_mid_word_idle, clk_i, rst_ni, s_acc && !s_axis_tlast,
                  state_q == ST_IDLE, "left idle inside a word")
  `GTJ_ASSERT_IMP(a_div_result, clk_i, rst_ni, div_done && state_q == ST_DIV,
                  (CHKW'(div_quo) * CHKW'(div_gaps) + CHKW'(div_rem)) == CHKW'(div_total),
                  "gap split wrong")

endmodule

@@ hdl/gtj_div.sv @@
// Restoring divider, one quotient bit per cycle.
module gtj_div #(
  parameter int unsigned ND = 6,  // dividend / quotient width
  parameter int unsigned DV = 5   // divisor / remainder width
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [ND-1:0] dividend_i,
  input  logic [DV-1:0] divisor_i,
  output logic          done_o,
  output logic [ND-1:0] quotient_o,
  output logic [DV-1:0] remainder_o
);

  localparam int unsigned CNTW = $clog2(ND + 1);

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [ND-1:0]   dvd_q, dvd_d;
  logic [DV-1:0]   dvs_q, dvs_d;
  logic [DV-1:0]   rem_q, rem_d;
  logic [DV:0]     shifted;
  logic [DV:0]     diff;
  logic            ge;

  // trial subtract of the shifted partial remainder
  assign shifted = {rem_q, dvd_q[ND-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d = CNTW'(ND);
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = ge ? diff[DV-1:0] : shifted[DV-1:0];
      dvd_d = {dvd_q[ND-2:0], ge};
      if (cnt_q == CNTW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

@@ test/greedy_text_justifier_tb.sv @@
module greedy_text_justifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_SLOTS  = gtj_pkg::MAX_WIDTH / 2 + 1;
  localparam int unsigned SETTLE      = 200;      // longest word build plus margin
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned LIMIT       = 1500000;

  typedef struct {
    logic [gtj_pkg::CHAR_W-1:0] code;
    logic                       word_end;
    logic                       text_end;
  } char_item_t;

  typedef struct packed {
    logic [gtj_pkg::CHAR_W-1:0] code;
    logic                       line_end;
    logic                       text_done;
  } line_char_t;

  typedef enum logic [2:0] {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH,
    PACE_HOLD
  } pace_e;

  logic                       clk_i  = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [gtj_pkg::CFG_W-1:0]  cfg_wdata_i = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [gtj_pkg::CHAR_W-1:0] s_axis_tdata = '0;   // [7:0] char_code
  logic                       s_axis_tlast = 1'b0; // word_end
  logic                       s_axis_tuser = 1'b0; // [0] text_end
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [gtj_pkg::CHAR_W-1:0] m_axis_tdata;        // [7:0] out_char
  logic                       m_axis_tlast;        // line_end
  logic                       m_axis_tuser;        // [0] text_done

  greedy_text_justifier uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock and reset
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  char_item_t  char_q[$];       // characters waiting to be offered
  line_char_t  justified_q[$];  // predicted line characters, oldest first
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_on = 1'b0;
  bit          hold_active = 1'b0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_count = 0;

  // ---------------------------------------------------------------
  // Justifier model state
  logic [gtj_pkg::CFG_W-1:0]  width_reg = gtj_pkg::LINE_WIDTH_RST;
  logic [gtj_pkg::CHAR_W-1:0] line_buf [gtj_pkg::MAX_WIDTH];
  logic [5:0]                 len_buf  [WORD_SLOTS];
  logic [gtj_pkg::CHAR_W-1:0] word_buf [gtj_pkg::MAX_WIDTH];
  int unsigned                n_words = 0;
  int unsigned                n_line_chars = 0;
  int unsigned                n_word_chars = 0;

  // width 0 behaves as 1, anything above the buffer size as the buffer size
  function automatic int unsigned line_cols();
    if (width_reg == 0) return 1;
    if (width_reg > gtj_pkg::MAX_WIDTH) return gtj_pkg::MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic void clear_text();
    n_words      = 0;
    n_line_chars = 0;
    n_word_chars = 0;
  endfunction

  // Lay out the pending line and queue its characters
  function automatic void flush_line(bit full, bit last);
    logic [gtj_pkg::CHAR_W-1:0] row [gtj_pkg::MAX_WIDTH];
    line_char_t                 lc;
    int unsigned                w, gap, extra, pos, src, k, i;
    w     = line_cols();
    gap   = 1;
    extra = 0;
    pos   = 0;
    src   = 0;
    foreach (row[j]) row[j] = gtj_pkg::SPACE_CODE;
    // spread the spare columns, leftmost gaps get the remainder
    if (full && n_words > 1 && n_line_chars <= w) begin
      gap   = (w - n_line_chars) / (n_words - 1);
      extra = (w - n_line_chars) % (n_words - 1);
    end
    for (k = 0; k < n_words && k < WORD_SLOTS; k++) begin
      if (k > 0) begin
        pos += gap;
        if (k <= extra) pos++;
      end
      for (i = 0; i < len_buf[k]; i++) begin
        if (pos < w && src < gtj_pkg::MAX_WIDTH) row[pos] = line_buf[src];
        pos++;
        src++;
      end
    end
    for (i = 0; i < w; i++) begin
      lc.code      = row[i];
      lc.line_end  = (i + 1 == w);
      lc.text_done = lc.line_end && last;
      justified_q.insert(justified_q.size(), lc);
    end
    n_words      = 0;
    n_line_chars = 0;
  endfunction

  // One accepted character
  function automatic void take_char(logic [gtj_pkg::CHAR_W-1:0] code, logic wend,
                                    logic tend);
    int unsigned w, i;
    w = line_cols();
    // over-long words lose their tail
    if (n_word_chars < w && n_word_chars < gtj_pkg::MAX_WIDTH) begin
      word_buf[n_word_chars] = code;
      n_word_chars++;
    end
    if (!wend) return;
    if (n_words > 0 && n_line_chars + n_words + n_word_chars > w)
      flush_line(n_words > 1, 1'b0);
    if (n_words < WORD_SLOTS) begin
      for (i = 0; i < n_word_chars; i++)
        if (n_line_chars + i < gtj_pkg::MAX_WIDTH)
          line_buf[n_line_chars + i] = word_buf[i];
      len_buf[n_words] = 6'(n_word_chars);
      n_words++;
      n_line_chars += n_word_chars;
    end
    n_word_chars = 0;
    if (tend) flush_line(1'b0, 1'b1);
  endfunction

  // ---------------------------------------------------------------
  // Character driver
  always @(posedge clk_i) begin : drive_chars
    char_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = char_q.pop_front();
        s_axis_tdata  <= item.code;
        s_axis_tlast  <= item.word_end;
        s_axis_tuser  <= item.text_end;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Accepted characters feed the model
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      take_char(s_axis_tdata, s_axis_tlast, s_axis_tuser);
  end

  // Long sink hold-off, counted in cycles
  always @(posedge clk_i) begin : hold_timer
    if (hold_on && hold_count < HOLD_CYCLES) begin
      hold_count  <= hold_count + 1;
      hold_active <= 1'b1;
    end else begin
      hold_active <= 1'b0;
    end
  end

  // Line sink: random stalls, one long hold-off when asked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_active) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each line word against the oldest prediction
  always @(posedge clk_i) begin : check_lines
    line_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (justified_q.size() == 0) begin
        $error("unexpected line word: out_char %0h line_end %0b text_done %0b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        n_errors++;
      end else begin
        want = justified_q.pop_front();
        if (m_axis_tdata !== want.code) begin
          $error("out_char: expected %0h, got %0h", want.code, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tlast !== want.line_end) begin
          $error("line_end: expected %0b, got %0b", want.line_end, m_axis_tlast);
          n_errors++;
        end
        if (m_axis_tuser !== want.text_done) begin
          $error("text_done: expected %0b, got %0b", want.text_done, m_axis_tuser);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus helpers
  function automatic void add_char(logic [gtj_pkg::CHAR_W-1:0] code, logic wend,
                                   logic tend);
    char_item_t it;
    it.code     = code;
    it.word_end = wend;
    it.text_end = tend;
    char_q.insert(char_q.size(), it);
  endfunction

  // Block until everything offered is taken and every line is out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (char_q.size() != 0 || s_axis_tvalid || justified_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_width(logic [gtj_pkg::CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    width_reg = value;
    clear_text();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_pace(pace_e pace);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_on       = 1'b0;
    case (pace)
      PACE_SEND_IDLE:  send_idle_pct = 79;
      PACE_RECV_STALL: recv_idle_pct = 79;
      PACE_BOTH: begin
        send_idle_pct = 36;
        recv_idle_pct = 36;
      end
      PACE_HOLD:       hold_on = 1'b1;
      default: ;
    endcase
  endtask

  // Random words, mostly short, some filling or overflowing the line
  task automatic queue_words(int unsigned n_chars, bit close_text);
    int unsigned w, len, made, r, i;
    logic        tend;
    w    = line_cols();
    made = 0;
    while (made < n_chars) begin
      r = $urandom_range(99);
      if (r < 80)      len = $urandom_range(1, (w < 8) ? w : 8);
      else if (r < 90) len = $urandom_range(1, w);
      else             len = w + $urandom_range(1, 3);
      for (i = 0; i < len; i++) begin
        if (i == len - 1) begin
          tend = ($urandom_range(5) == 0) || (close_text && made + 1 >= n_chars);
          add_char(8'($urandom_range(255)), 1'b1, tend);
        end else begin
          // stray text_end inside a word must be ignored
          add_char(8'($urandom_range(255)), 1'b0, $urandom_range(9) == 0);
        end
        made++;
      end
    end
  endtask

  task automatic run_phase(logic [gtj_pkg::CFG_W-1:0] width, pace_e pace,
                           int unsigned n_chars, bit close_text);
    write_width(width);
    set_pace(pace);
    queue_words(n_chars, close_text);
    wait_drained();
  endtask

  // ---------------------------------------------------------------
  // Test sequence
  initial begin : run_test
    int unsigned i;
    wait (rst_ni);
    @(negedge clk_i);

    // Reset width 16: three words fully justified with an uneven gap, then a
    // word that both pushes that line out and ends the text.
    add_char(8'h00, 1'b1, 1'b0);
    add_char(8'hff, 1'b0, 1'b1);
    add_char(8'hff, 1'b0, 1'b0);
    add_char(8'hff, 1'b1, 1'b0);
    for (i = 0; i < 5; i++) add_char(8'(8'h61 + i), i == 4, 1'b0);
    for (i = 0; i < 6; i++) add_char(8'(8'h80 + i), i == 5, i == 5);
    wait_drained();

    // Width 4: a lone word goes out left-justified, an over-long word is cut
    write_width(6'd4);
    add_char(8'h78, 1'b0, 1'b0);
    add_char(8'h79, 1'b1, 1'b0);
    for (i = 0; i < 7; i++) add_char(8'(8'h41 + i), i == 6, i == 6);
    wait_drained();

    // Random texts over several widths and pacing modes
    run_phase(6'd32, PACE_FREE,       30, 1'b1);
    run_phase(6'd0,  PACE_RECV_STALL, 20, 1'b1);
    run_phase(6'd63, PACE_SEND_IDLE,  25, 1'b0);  // left open: next write drops it
    run_phase(6'd7,  PACE_BOTH,       30, 1'b1);
    run_phase(6'd1,  PACE_FREE,       20, 1'b1);
    run_phase(6'd2,  PACE_RECV_STALL, 25, 1'b1);
    run_phase(6'd12, PACE_BOTH,       25, 1'b0);
    run_phase(6'd5,  PACE_HOLD,       45, 1'b1);
    run_phase(6'($urandom_range(3, 31)), PACE_SEND_IDLE, 25, 1'b1);

    if (justified_q.size() != 0)
      $error("%0d predicted line words never arrived", justified_q.size());
    if (n_errors == 0 && justified_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/gtj_pkg.sv
hdl/gtj_div.sv
hdl/greedy_text_justifier.sv
test/greedy_text_justifier_tb.sv
